[hdl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  // Console geometry
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_CELLS  = 2000;
  localparam int CONSOLE_CELLS = 8000;

  // Derived widths
  localparam int OFF_W  = $clog2(CONSOLE_CELLS + SCREEN_WIDTH);
  localparam int MEM_AW = $clog2(CONSOLE_CELLS);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int CMP_W  = $clog2(CONSOLE_CELLS + SCREEN_WIDTH + SCREEN_CELLS);
  localparam int SC_MOD = SCREEN_CELLS % SCREEN_WIDTH;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 13;
  localparam int ADDR_W = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 2'd0,
    CMD_VIEW_BACK = 2'd1,
    CMD_VIEW_FWD  = 2'd2,
    CMD_READ      = 2'd3
  } tcw_cmd_e;

  typedef enum logic [3:0] {
    ST_BLANK,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_NL,
    ST_BSCAN,
    ST_CHK,
    ST_COPY,
    ST_RESP
  } tcw_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_address;
    logic [ADDR_W-1:0] display_start;
    logic [CHAR_W-1:0] cell_char;
    logic              wrapped;
  } tcw_out_t;

  // Cell store access: one write and one read per cycle
  typedef struct packed {
    logic              we;
    logic [OFF_W-1:0]  waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [OFF_W-1:0]  raddr;
  } tcw_mem_req_t;

endpackage

`default_nettype wire

[hdl/tcw_cell_store.sv]
`default_nettype none

module tcw_cell_store (
  input  wire                         clk_i,
  input  tcw_pkg::tcw_mem_req_t       req_i,
  output logic [tcw_pkg::CHAR_W-1:0]  rdata_o
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] mem [CONSOLE_CELLS];
  logic [CHAR_W-1:0] data_q;
  logic              oob_q;

  // Drop writes beyond the region end
  always_ff @(posedge clk_i) begin
    if (req_i.we && (32'(req_i.waddr) < 32'(CONSOLE_CELLS))) begin
      mem[req_i.waddr[MEM_AW-1:0]] <= req_i.wdata;
    end
  end

  // Cells beyond the region end read as space
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      oob_q <= !(32'(req_i.raddr) < 32'(CONSOLE_CELLS));
      if (32'(req_i.raddr) < 32'(CONSOLE_CELLS)) begin
        data_q <= mem[req_i.raddr[MEM_AW-1:0]];
      end
    end
  end

  assign rdata_o = oob_q ? CODE_SPACE : data_q;

endmodule

`default_nettype wire

[hdl/text_console_writer.sv]
// Text console writer: one command at a time; the input stalls until its result is loaded.
// A put that fills the region adds a copy and then a blanking pass, one cell per cycle through
// the store port. The sequencer holds a finished result until the output register is free.
// Reset clears every cell to space; the config port is live throughout.
`default_nettype none

module text_console_writer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // command channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  tcw_pkg::tcw_in_t                 in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output tcw_pkg::tcw_out_t                out_data_o,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [2:0]                       paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import tcw_pkg::*;

  localparam logic [OFF_W-1:0]  ONE_OFF = OFF_W'(1);
  localparam logic [OFF_W-1:0]  W_OFF   = OFF_W'(SCREEN_WIDTH);
  localparam logic [OFF_W-1:0]  CC_OFF  = OFF_W'(CONSOLE_CELLS);
  localparam logic [CMP_W-1:0]  SC_CMP  = CMP_W'(SCREEN_CELLS);
  localparam logic [COL_W-1:0]  COL_MAX = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [COL_W:0]    W_COL   = (COL_W+1)'(SCREEN_WIDTH);
  localparam logic [COL_W:0]    SCM_COL = (COL_W+1)'(SC_MOD);

  // ---------------------------------------------------------------------------
  // Configuration register: console origin at word 0, pready tied high
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      origin_q <= pwdata[ADDR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, origin_q};

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  tcw_state_e        state_q, state_d;
  logic [OFF_W-1:0]  cursor_q, cursor_d;
  logic [OFF_W-1:0]  view_q, view_d;
  logic [COL_W-1:0]  col_q, col_d;      // cursor column, kept equal to cursor % width
  logic [OFF_W-1:0]  ptr_q, ptr_d;      // blanking pointer
  logic              wrapped_q, wrapped_d;
  logic              wr_pend_q, wr_pend_d;
  logic              out_valid_q;

  // Payload registers, no reset needed
  tcw_cmd_e          cmd_q, cmd_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CHAR_W-1:0] cell_q, cell_d;
  logic [COL_W-1:0]  cnt_q, cnt_d;      // backspace cells still allowed
  logic              first_q, first_d;
  logic [OFF_W-1:0]  copy_q, copy_d;
  logic [OFF_W-1:0]  src_q, src_d;
  logic [OFF_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic [OFF_W-1:0]  wr_idx_q, wr_idx_d;
  tcw_out_t          out_q;

  tcw_mem_req_t      mem_req;
  logic [CHAR_W-1:0] mem_rdata;
  logic              out_load;

  tcw_cell_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Column step helpers
  logic [COL_W-1:0] col_inc, col_dec;
  assign col_inc = (col_q == COL_MAX) ? '0 : col_q + COL_W'(1);
  assign col_dec = (col_q == '0) ? COL_MAX : col_q - COL_W'(1);

  // View test shared by put and view forward: cursor a full screen past view start
  logic view_behind;
  assign view_behind = CMP_W'(cursor_q) >= (CMP_W'(view_q) + SC_CMP);

  // Wrap geometry: keep the last rows that fit in one screen
  logic [COL_W:0]   tail;
  logic [CMP_W-1:0] copy_raw;
  logic [COL_W:0]   col_sum;
  logic [OFF_W-1:0] wrap_copy;
  logic [COL_W-1:0] wrap_col;

  always_comb begin
    tail     = W_COL - {1'b0, col_q};
    copy_raw = (SC_CMP > CMP_W'(tail)) ? SC_CMP - CMP_W'(tail) : '0;
    col_sum  = SCM_COL + {1'b0, col_q};
    if (copy_raw > CMP_W'(cursor_q)) begin
      // copy clamped to the whole region: cursor column is unchanged
      wrap_copy = cursor_q;
      wrap_col  = col_q;
    end else if (copy_raw == '0) begin
      wrap_copy = '0;
      wrap_col  = '0;
    end else begin
      wrap_copy = OFF_W'(copy_raw);
      wrap_col  = (col_sum >= W_COL) ? COL_W'(col_sum - W_COL) : COL_W'(col_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state and store access
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [OFF_W-1:0] cur_dec;
    logic [COL_W-1:0] cnt_new;

    state_d   = state_q;
    cursor_d  = cursor_q;
    view_d    = view_q;
    col_d     = col_q;
    ptr_d     = ptr_q;
    wrapped_d = wrapped_q;
    wr_pend_d = wr_pend_q;
    cmd_d     = cmd_q;
    char_d    = char_q;
    idx_d     = idx_q;
    cell_d    = cell_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    copy_d    = copy_q;
    src_d     = src_q;
    rd_cnt_d  = rd_cnt_q;
    wr_idx_d  = wr_idx_q;
    mem_req   = '0;
    out_load  = 1'b0;
    cur_dec   = cursor_q - ONE_OFF;
    cnt_new   = first_q ? COL_MAX : cnt_q - COL_W'(1);

    case (state_q)
      ST_BLANK: begin
        // blank one cell a cycle up to the region end
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_q;
        mem_req.wdata = CODE_SPACE;
        if (ptr_q >= CC_OFF - ONE_OFF) begin
          state_d = wrapped_q ? ST_RESP : ST_IDLE;
        end else begin
          ptr_d = ptr_q + ONE_OFF;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = tcw_cmd_e'(in_data_i.command);
          char_d    = in_data_i.char_code;
          idx_d     = in_data_i.cell_index;
          wrapped_d = 1'b0;
          cell_d    = '0;
          state_d   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (cmd_q)
          CMD_PUT: begin
            if (char_q == CODE_NUL) begin
              state_d = ST_RESP;
            end else if (char_q == CODE_NEWLINE) begin
              state_d = ST_NL;
            end else if (char_q == CODE_BACKSPACE) begin
              if (cursor_q == '0) begin
                state_d = ST_CHK;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_dec;
                first_d       = 1'b1;
                state_d       = ST_BSCAN;
              end
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cursor_q;
              mem_req.wdata = char_q;
              cursor_d      = cursor_q + ONE_OFF;
              col_d         = col_inc;
              state_d       = ST_CHK;
            end
          end
          CMD_VIEW_BACK: begin
            view_d  = (view_q >= W_OFF) ? view_q - W_OFF : '0;
            state_d = ST_RESP;
          end
          CMD_VIEW_FWD: begin
            if (view_behind) begin
              view_d = view_q + W_OFF;
            end
            state_d = ST_RESP;
          end
          CMD_READ: begin
            if (32'(idx_q) < 32'(CONSOLE_CELLS)) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = OFF_W'(idx_q);
              state_d       = ST_RDWAIT;
            end else begin
              state_d = ST_RESP;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end

      ST_RDWAIT: begin
        cell_d  = mem_rdata;
        state_d = ST_RESP;
      end

      ST_NL: begin
        // fill the rest of the row with zero markers
        mem_req.we    = 1'b1;
        mem_req.waddr = cursor_q;
        mem_req.wdata = CODE_NUL;
        cursor_d      = cursor_q + ONE_OFF;
        col_d         = col_inc;
        if (col_q == COL_MAX) begin
          state_d = ST_CHK;
        end
      end

      ST_BSCAN: begin
        if (mem_rdata != CODE_NUL) begin
          if (first_q) begin
            // previous cell holds a character: blank it
            mem_req.we    = 1'b1;
            mem_req.waddr = cur_dec;
            mem_req.wdata = CODE_SPACE;
            cursor_d      = cur_dec;
            col_d         = col_dec;
          end
          state_d = ST_CHK;
        end else begin
          // back over one zero marker, look at the next one down
          cursor_d = cur_dec;
          col_d    = col_dec;
          cnt_d    = cnt_new;
          first_d  = 1'b0;
          if ((cnt_new != '0) && (cur_dec != '0)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = cur_dec - ONE_OFF;
          end else begin
            state_d = ST_CHK;
          end
        end
      end

      ST_CHK: begin
        if (cursor_q >= CC_OFF) begin
          wrapped_d = 1'b1;
          view_d    = '0;
          cursor_d  = wrap_copy;
          col_d     = wrap_col;
          copy_d    = wrap_copy;
          src_d     = cursor_q - wrap_copy;
          rd_cnt_d  = '0;
          wr_idx_d  = '0;
          wr_pend_d = 1'b0;
          ptr_d     = wrap_copy;
          state_d   = ST_COPY;
        end else begin
          if (view_behind) begin
            view_d = view_q + W_OFF;
          end
          state_d = ST_RESP;
        end
      end

      ST_COPY: begin
        // read ahead one cell, write the cell read last cycle
        if (wr_pend_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_idx_q;
          mem_req.wdata = mem_rdata;
          wr_idx_d      = wr_idx_q + ONE_OFF;
        end
        if (rd_cnt_q != copy_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = src_q;
          src_d         = src_q + ONE_OFF;
          rd_cnt_d      = rd_cnt_q + ONE_OFF;
          wr_pend_d     = 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          state_d   = ST_BLANK;
        end
      end

      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_BLANK;
      cursor_q  <= '0;
      view_q    <= '0;
      col_q     <= '0;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      view_q    <= view_d;
      col_q     <= col_d;
      ptr_q     <= ptr_d;
      wrapped_q <= wrapped_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    char_q   <= char_d;
    idx_q    <= idx_d;
    cell_q   <= cell_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    copy_q   <= copy_d;
    src_q    <= src_d;
    rd_cnt_q <= rd_cnt_d;
    wr_idx_q <= wr_idx_d;
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result until its transfer completes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.cursor_address <= origin_q + ADDR_W'(cursor_q);
      out_q.display_start  <= origin_q + ADDR_W'(view_q);
      out_q.cell_char      <= cell_q;
      out_q.wrapped        <= wrapped_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a command is in progress");

  a_cursor_in_region : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cursor_q < CC_OFF)
    else $error("cursor left the region between commands");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_req.we)
    else $error("cell store written while idle");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !out_load)
    else $error("two results loaded back to back");

endmodule

`default_nettype wire
